// ===== rtl/mbtg_pkg.sv =====
// shared types, constants and helper functions for the page-tag to grouped text converter
// no dependencies

package mbtg_pkg;

    // page state
    localparam logic [7:0] NO_PAGE = 8'd127;

    // page tags that carry a macro
    localparam logic [7:0] TAG_IT  = 8'd129;
    localparam logic [7:0] TAG_CZ  = 8'd130;
    localparam logic [7:0] TAG_RUS = 8'd140;

    // output characters
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_S     = 8'h53;

    // command queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MAC_NONE,
        MAC_IT,
        MAC_CZ,
        MAC_RUS
    } t_macro;

    // one classified source byte: what the back end has to emit, in this order
    typedef struct packed {
        logic       close_first;
        logic       open_grp;
        t_macro     macro;
        logic       has_byte;
        logic [7:0] data;
        logic       close_last;
    } t_cmd;

    function automatic t_macro tag_macro(input logic [7:0] tag);
        t_macro m;
        unique case (tag)
            TAG_IT:  m = MAC_IT;
            TAG_CZ:  m = MAC_CZ;
            TAG_RUS: m = MAC_RUS;
            default: m = MAC_NONE;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] macro_len(input t_macro m);
        logic [2:0] len;
        unique case (m)
            MAC_NONE: len = 3'd0;
            MAC_IT:   len = 3'd4;
            MAC_CZ:   len = 3'd4;
            MAC_RUS:  len = 3'd5;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] macro_char(input t_macro m, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_SPACE;
        unique case (m)
            MAC_NONE: ch = CH_SPACE;
            MAC_IT: begin
                unique case (pos)
                    3'd0:    ch = CH_BSL;
                    3'd1:    ch = CH_I;
                    3'd2:    ch = CH_T;
                    default: ch = CH_SPACE;
                endcase
            end
            MAC_CZ: begin
                unique case (pos)
                    3'd0:    ch = CH_BSL;
                    3'd1:    ch = CH_C;
                    3'd2:    ch = CH_Z;
                    default: ch = CH_SPACE;
                endcase
            end
            MAC_RUS: begin
                unique case (pos)
                    3'd0:    ch = CH_BSL;
                    3'd1:    ch = CH_R;
                    3'd2:    ch = CH_U;
                    3'd3:    ch = CH_S;
                    default: ch = CH_SPACE;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/mbtg_in_if.sv =====
// input channel: one source byte per transfer
// no dependencies

interface mbtg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

// ===== rtl/mbtg_out_if.sv =====
// output channel: one byte of converted text per transfer
// no dependencies

interface mbtg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/mbtg_front.sv =====
// front end: tracks page and group state, turns each source byte into a command
// uses mbtg_pkg

module mbtg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    input  logic                i_end_of_string,
    output logic                o_push,
    output mbtg_pkg::t_cmd      o_cmd
);

    logic [7:0] r_page, n_page;
    logic       r_group_open, n_group_open;
    logic       r_expect_data, n_expect_data;
    mbtg_pkg::t_cmd cmd;

    always_comb begin
        cmd           = '0;
        cmd.macro     = mbtg_pkg::MAC_NONE;
        cmd.data      = i_in_byte;
        n_page        = r_page;
        n_group_open  = r_group_open;
        n_expect_data = r_expect_data;

        if (r_expect_data) begin
            // data byte after a tag, copied as is
            cmd.has_byte  = 1'b1;
            n_expect_data = 1'b0;
        end else if (i_in_byte[7]) begin
            if (i_in_byte != r_page) begin
                cmd.close_first = r_group_open;
                cmd.open_grp    = 1'b1;
                cmd.macro       = mbtg_pkg::tag_macro(i_in_byte);
                n_page          = i_in_byte;
                n_group_open    = 1'b1;
            end
            n_expect_data = 1'b1;
        end else begin
            cmd.has_byte = 1'b1;
        end

        if (i_end_of_string) begin
            cmd.close_last = n_group_open;
            n_page         = mbtg_pkg::NO_PAGE;
            n_group_open   = 1'b0;
            n_expect_data  = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && (cmd.close_first || cmd.open_grp || cmd.has_byte
                                 || cmd.close_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page        <= mbtg_pkg::NO_PAGE;
            r_group_open  <= 1'b0;
            r_expect_data <= 1'b0;
        end else if (i_accept) begin
            r_page        <= n_page;
            r_group_open  <= n_group_open;
            r_expect_data <= n_expect_data;
        end
    end

endmodule

// ===== rtl/mbtg_queue.sv =====
// small command queue between front and back end
// uses mbtg_pkg

module mbtg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mbtg_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output mbtg_pkg::t_cmd      o_cmd
);

    mbtg_pkg::t_cmd                r_mem [mbtg_pkg::QDEPTH];
    logic [mbtg_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [mbtg_pkg::QCNT_W-1:0]   r_cnt;
    logic                          do_push, do_pop;

    assign o_full  = (r_cnt == mbtg_pkg::QCNT_W'(mbtg_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mbtg_pkg::QCNT_W'(mbtg_pkg::QDEPTH))
        else $error("command queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");
`endif

endmodule

// ===== rtl/mbtg_back.sv =====
// back end: expands one command into the output register, a byte per cycle unless stalled
// uses mbtg_pkg

module mbtg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  mbtg_pkg::t_cmd      i_q_cmd,
    output logic                o_pop,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_run_last
);

    logic           r_busy;
    mbtg_pkg::t_cmd r_cmd, n_cmd;
    logic [2:0]     r_mpos, n_mpos;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_last;

    logic           can_load, emit, done, last;
    logic [7:0]     sel_byte;

    // pick the next element of the command and strip it off
    always_comb begin
        n_cmd    = r_cmd;
        n_mpos   = r_mpos;
        sel_byte = mbtg_pkg::CH_CLOSE;
        priority if (r_cmd.close_first) begin
            sel_byte          = mbtg_pkg::CH_CLOSE;
            n_cmd.close_first = 1'b0;
        end else if (r_cmd.open_grp) begin
            sel_byte       = mbtg_pkg::CH_OPEN;
            n_cmd.open_grp = 1'b0;
        end else if (r_cmd.macro != mbtg_pkg::MAC_NONE) begin
            sel_byte = mbtg_pkg::macro_char(r_cmd.macro, r_mpos);
            if (r_mpos == mbtg_pkg::macro_len(r_cmd.macro) - 3'd1) begin
                n_cmd.macro = mbtg_pkg::MAC_NONE;
                n_mpos      = 3'd0;
            end else begin
                n_mpos = r_mpos + 3'd1;
            end
        end else if (r_cmd.has_byte) begin
            sel_byte       = r_cmd.data;
            n_cmd.has_byte = 1'b0;
        end else begin
            sel_byte         = mbtg_pkg::CH_CLOSE;
            n_cmd.close_last = 1'b0;
        end
    end

    assign last = !(n_cmd.close_first || n_cmd.open_grp
                    || (n_cmd.macro != mbtg_pkg::MAC_NONE)
                    || n_cmd.has_byte || n_cmd.close_last);

    assign can_load = !r_out_valid || i_out_ready;
    assign emit     = r_busy && can_load;
    assign done     = emit && last;
    assign o_pop    = i_q_valid && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_q_cmd;
            r_mpos <= 3'd0;
        end else if (emit) begin
            r_cmd  <= n_cmd;
            r_mpos <= n_mpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

`ifndef SYNTHESIS
    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cmd.close_first || r_cmd.open_grp
                    || (r_cmd.macro != mbtg_pkg::MAC_NONE)
                    || r_cmd.has_byte || r_cmd.close_last))
        else $error("back end busy with an empty command");

    a_mpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cmd.macro != mbtg_pkg::MAC_NONE))
            |-> (r_mpos < mbtg_pkg::macro_len(r_cmd.macro)))
        else $error("macro position past end of macro");
`endif

endmodule

// ===== rtl/multibyte_tag_to_tex_groups.sv =====
// top level of the page-tag to grouped text converter
// uses mbtg_pkg, mbtg_in_if, mbtg_out_if, mbtg_front, mbtg_queue, mbtg_back

// usage
//   i_in  : one source byte per transfer (in_byte, end_of_string marks the final byte)
//   o_out : one byte of converted text per transfer, run_last on the last byte
//           caused by a given source byte
//   a byte below 128 passes through, a byte of 128 or more is a page tag and the
//   byte after it passes through unchanged; a page change closes the open group
//   with '}', opens '{' and adds any page macro; end of string closes the group
// timing
//   front end classifies one source byte per cycle while the queue has room and
//   pushes a command into a four-entry queue; back end drains one command, one
//   output byte per cycle while the receiver is ready
//   path to the first output byte: queue entry, command register, output register
//   throughput: one source byte per cycle while each makes one output byte and the
//   receiver is ready; a page change makes up to eight bytes, the queue absorbs the
//   burst while input keeps flowing until it fills; a repeated tag makes no output
// reset and stall
//   synchronous reset clears page state, queue and output register
//   a stalled receiver holds the output register; the back end then stops and
//   the queue fills, after which i_in.ready drops

module multibyte_tag_to_tex_groups (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbtg_in_if.sink           i_in,
    mbtg_out_if.source        o_out
);

    logic           accept;
    logic           push;
    mbtg_pkg::t_cmd push_cmd;
    logic           q_full;
    logic           q_valid;
    mbtg_pkg::t_cmd q_cmd;
    logic           pop;

    // input transfer whenever the queue has room
    assign i_in.ready = !q_full;
    assign accept     = i_in.valid && !q_full;

    mbtg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_in_byte       (i_in.in_byte),
        .i_end_of_string (i_in.end_of_string),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    mbtg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back end owns the output register
    mbtg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_run_last  (o_out.run_last)
    );

endmodule

// ===== test/tb.sv =====
// self-checking bench for multibyte_tag_to_tex_groups: page-tagged bytes in, grouped text out
// depends on mbtg_pkg, mbtg_in_if, mbtg_out_if and the rtl of the converter

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} t_text_byte;

// scoreboard: tracks the page state and keeps the text bytes still to come
class text_scoreboard;
    logic [7:0] page;
    bit         grp_open;
    bit         want_data;
    t_text_byte text_q[$];
    int         errors;
    int         n_in;
    int         n_out;
    int         n_switch;

    function new();
        errors = 0;
        n_in = 0;
        n_out = 0;
        n_switch = 0;
        clear_page();
    endfunction

    function void clear_page();
        page = mbtg_pkg::NO_PAGE;
        grp_open = 1'b0;
        want_data = 1'b0;
    endfunction

    function int pending();
        return text_q.size();
    endfunction

    // one accepted source byte: work out the text bytes it causes
    function void note_input(logic [7:0] src, logic eos);
        logic [7:0] burst[$];
        logic [7:0] macro_text[$];
        n_in++;
        if (want_data) begin
            burst.push_back(src);
            want_data = 1'b0;
        end else if (src > mbtg_pkg::NO_PAGE) begin
            if (src != page) begin
                n_switch++;
                if (grp_open) begin
                    burst.push_back(mbtg_pkg::CH_CLOSE);
                end
                grp_open = 1'b1;
                burst.push_back(mbtg_pkg::CH_OPEN);
                case (src)
                    mbtg_pkg::TAG_IT: begin
                        macro_text = '{mbtg_pkg::CH_BSL, mbtg_pkg::CH_I, mbtg_pkg::CH_T,
                                       mbtg_pkg::CH_SPACE};
                    end
                    mbtg_pkg::TAG_CZ: begin
                        macro_text = '{mbtg_pkg::CH_BSL, mbtg_pkg::CH_C, mbtg_pkg::CH_Z,
                                       mbtg_pkg::CH_SPACE};
                    end
                    mbtg_pkg::TAG_RUS: begin
                        macro_text = '{mbtg_pkg::CH_BSL, mbtg_pkg::CH_R, mbtg_pkg::CH_U,
                                       mbtg_pkg::CH_S, mbtg_pkg::CH_SPACE};
                    end
                    default: begin
                        macro_text.delete();
                    end
                endcase
                foreach (macro_text[k]) begin
                    burst.push_back(macro_text[k]);
                end
                page = src;
            end
            want_data = 1'b1;
        end else begin
            burst.push_back(src);
        end
        if (eos) begin
            if (grp_open) begin
                burst.push_back(mbtg_pkg::CH_CLOSE);
            end
            clear_page();
        end
        foreach (burst[k]) begin
            text_q.push_back(t_text_byte'{burst[k], k == burst.size() - 1});
        end
    endfunction

    // one accepted text byte against the oldest one expected
    function void check_result(logic [7:0] ch, logic last);
        t_text_byte want;
        n_out++;
        if (text_q.size() == 0) begin
            errors++;
            $display("%0t: text byte %02h run_last %0b arrived with none expected",
                     $time, ch, last);
        end else begin
            want = text_q.pop_front();
            if (want.ch !== ch || want.last !== last) begin
                errors++;
                $display("%0t: expected byte %02h run_last %0b, got byte %02h run_last %0b",
                         $time, want.ch, want.last, ch, last);
            end
        end
    endfunction
endclass

module tb;

    localparam int HOLD_CYCLES = 80;     // long receiver hold-off
    localparam int IDLE_LIMIT  = 2000;   // cycles without any transfer
    localparam int ITEM_TARGET = 300;    // directed plus random source bytes
    localparam int TAIL_CYCLES = 16;     // pipeline delay plus the longest burst, with margin

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbtg_in_if  in_ch ();
    mbtg_out_if out_ch ();

    multibyte_tag_to_tex_groups i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    text_scoreboard sb = new();

    bit tx_calm = 1'b0;     // sender offers back to back
    bit rx_calm = 1'b0;     // receiver never stalls
    bit hold_rx = 1'b0;     // request for one long receiver hold-off
    int items_sent = 0;
    int idle_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // offer one source byte, optionally after a gap, and wait for its transfer
    task automatic push_byte(input logic [7:0] src, input logic eos);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= src;
        in_ch.end_of_string <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(src, eos);
        items_sent++;
    endtask

    // sender pause: nothing offered until every expected text byte has come
    task automatic drain_out();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // one source string of ASCII and tag/data pairs; a broken one ends at a random
    // byte, possibly on a tag
    task automatic send_text(input int n_units, input bit broken);
        logic [7:0] bytes[$];
        logic [7:0] last_tag;
        logic [7:0] tag;
        int cut;
        last_tag = mbtg_pkg::TAG_IT;
        for (int i = 0; i < n_units; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0:       tag = mbtg_pkg::TAG_IT;
                    1:       tag = mbtg_pkg::TAG_CZ;
                    2:       tag = mbtg_pkg::TAG_RUS;
                    3:       tag = last_tag;   // same page again
                    default: tag = 8'($urandom_range(128, 255));
                endcase
                last_tag = tag;
                bytes.push_back(tag);
                bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                bytes.push_back(8'($urandom_range(0, 127)));
            end
        end
        cut = broken ? $urandom_range(0, bytes.size() - 1) : bytes.size() - 1;
        for (int k = 0; k <= cut; k++) begin
            push_byte(bytes[k], k == cut);
        end
    endtask

    // transfer-level checking of the text stream, with random stalls
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.out_byte, out_ch.run_last);
            end
            if (hold_rx && i_rst_n) begin
                // long hold-off so the queue fills and the input stalls
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end else if (stall > 0 || !i_rst_n) begin
                out_ch.ready <= 1'b0;
                if (stall > 0) begin
                    stall--;
                end
            end else begin
                out_ch.ready <= 1'b1;
                if (!rx_calm) begin
                    stall = pick_gap();
                end
            end
        end
    end

    // watchdog: ends a run that stops moving
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int r;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.in_byte       <= 8'h00;
        in_ch.end_of_string <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every macro page, special cases
        push_byte(8'h00, 1'b0);                 // lowest ascii
        push_byte(8'h7F, 1'b0);                 // highest ascii, equals the no-page value
        push_byte(mbtg_pkg::TAG_IT, 1'b0);      // first group, no close before it
        push_byte(8'h41, 1'b0);
        push_byte(mbtg_pkg::TAG_IT, 1'b0);      // repeated tag, no text at all
        push_byte(8'hFF, 1'b0);                 // data byte of 128 or more copied as is
        push_byte(mbtg_pkg::TAG_CZ, 1'b0);      // page change closes the open group
        push_byte(8'h80, 1'b0);
        push_byte(mbtg_pkg::TAG_RUS, 1'b0);     // longest macro
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0);                 // lowest tag, no macro text
        push_byte(8'h78, 1'b0);
        push_byte(8'hFF, 1'b0);                 // highest tag, no macro text
        push_byte(8'd141, 1'b0);
        push_byte(8'h71, 1'b1);                 // end of string closes the group
        push_byte(mbtg_pkg::TAG_IT, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(mbtg_pkg::TAG_RUS, 1'b1);     // tag as final byte: eight text bytes
        push_byte(8'h7A, 1'b1);                 // end of string with no group open
        push_byte(8'd139, 1'b1);                // tag at end with nothing open
        push_byte(8'd131, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h55, 1'b1);

        // random strings with gaps on both sides
        while (items_sent < 130) begin
            send_text($urandom_range(1, 12), $urandom_range(0, 4) == 0);
        end

        // sender pause, then back-to-back input against a held receiver
        drain_out();
        tx_calm = 1'b1;
        hold_rx = 1'b1;
        repeat (3) send_text(8, 1'b0);
        tx_calm = 1'b0;

        // a stretch with no idling on either side
        rx_calm = 1'b1;
        tx_calm = 1'b1;
        while (items_sent < 230) begin
            send_text($urandom_range(1, 12), 1'b0);
        end
        rx_calm = 1'b0;
        tx_calm = 1'b0;

        // mostly well-formed strings, some broken ones and raw noise
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_text($urandom_range(1, 12), 1'b0);
            end else if (r < 9) begin
                send_text($urandom_range(1, 12), 1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                end
            end
        end

        drain_out();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d source bytes, %0d text bytes, %0d page switches",
                 sb.n_in, sb.n_out, sb.n_switch);
        $display("including a long output hold-off, a drained pause and gap-free stretches");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== multibyte_tag_to_tex_groups.f =====
rtl/mbtg_pkg.sv
rtl/mbtg_in_if.sv
rtl/mbtg_out_if.sv
rtl/mbtg_front.sv
rtl/mbtg_queue.sv
rtl/mbtg_back.sv
rtl/multibyte_tag_to_tex_groups.sv
test/tb.sv
